FILE: hdl/aeli_pkg.sv
// shared types, codes and defaults of the absorber energy-loss integrator
`timescale 1ns / 1ps
`default_nettype none

package aeli_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned WordW         = 32;
  localparam int unsigned WideW         = 64;
  localparam int unsigned SaW           = 40;

  localparam logic [1:0] ModeLoad = 2'd0;
  localparam logic [1:0] ModeSlow = 2'd1;
  localparam logic [1:0] ModeRev  = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StOrder = 2'd2;
  localparam logic [1:0] StFew   = 2'd3;

  localparam logic CfgEntryCount = 1'b0;
  localparam logic CfgStepTol    = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_LD_WRITE, OP_LD_DIFF, OP_LD_WAIT, OP_LD_STORE,
    OP_EPA_GO, OP_EPA_WAIT, OP_RD_FIRST, OP_RD_LAST, OP_RANGE,
    OP_SCAN_RD, OP_SCAN_CMP, OP_BIN_RD, OP_INTERP, OP_LOSS,
    OP_PROD_HI, OP_PROD_LO, OP_STEP_DIV, OP_STEP_WAIT, OP_SQRT_WAIT,
    OP_STEP_CLAMP, OP_DELTA, OP_APPLY, OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic       fin_zero;
    logic [1:0] fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_bad;
    logic       idx_zero;
    logic       few;
    logic       order_broken;
    logic       seg_pos;
    logic       div_done;
    logic       sqrt_done;
    logic       out_range;
    logic       n_gt2;
    logic       scan_more;
    logic       p_zero;
    logic       q_over;
    logic       last_step;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/aeli_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module aeli_div import aeli_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WideW-1:0] num_i,
  input  wire logic [WideW-1:0] den_i,
  output logic                  done_o,
  output logic      [WideW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(WideW) + 1;

  logic [WideW-1:0] quo_q, rem_q, den_q;
  logic [CntW-1:0]  cnt_q;
  logic             run_q, done_q;
  logic [WideW:0]   rem_sh, rem_nx;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[WideW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};
  assign rem_nx = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(WideW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      quo_q <= {quo_q[WideW-2:0], fits};
      rem_q <= rem_nx[WideW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

FILE: hdl/aeli_sqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module aeli_sqrt import aeli_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WideW-1:0] val_i,
  output logic                  done_o,
  output logic      [WordW-1:0] root_o
);

  localparam int unsigned Iter = WideW / 2;
  localparam int unsigned CntW = $clog2(Iter) + 1;

  logic [WideW-1:0] v_q, res_q, bit_q, trial;
  logic [CntW-1:0]  cnt_q;
  logic             run_q, done_q, take;

  assign trial = res_q + bit_q;
  assign take  = v_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == CntW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(Iter);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= WideW'(1) << (WideW - 2);
    end else if (run_q) begin
      if (take) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[WordW-1:0];

endmodule

`default_nettype wire

FILE: hdl/aeli_datapath.sv
// table memories, configuration, arithmetic and result registers
`timescale 1ns / 1ps
`default_nettype none

module aeli_datapath import aeli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dp_cmd_t          cmd_i,
  output dp_stat_t              stat_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [5:0]       entry_index_i,
  input  wire logic [WordW-1:0] energy_in_i,
  input  wire logic [WordW-1:0] loss_value_i,
  input  wire logic [WordW-1:0] thickness_i,
  input  wire logic [7:0]       mass_number_i,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [WordW-1:0] cfg_wdata_i,
  output logic                  done_o,
  output logic      [WordW-1:0] energy_out_o,
  output logic      [1:0]       status_o,
  output logic      [15:0]      step_count_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam logic [WordW-1:0] MinStep = WordW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [WordW-1:0] WordMax = '1;
  localparam logic [WordW-1:0] SlopePosMax = 32'h7FFF_FFFF;
  localparam logic [WideW-1:0] SlopeNegMax = 64'h8000_0000;

  // table storage
  logic [WordW-1:0] e_mem [TABLE_DEPTH];
  logic [WordW-1:0] l_mem [TABLE_DEPTH];
  logic [WordW-1:0] s_mem [TABLE_DEPTH];
  logic [WordW-1:0] e_rd_q, l_rd_q, s_rd_q;
  logic [AW-1:0]    rd_addr;

  // configuration and control state
  logic [6:0]       count_q;
  logic [WordW-1:0] tol_q;
  logic             ob_q;
  logic             out_valid_q;

  // working registers
  logic [1:0]       mode_q;
  logic [5:0]       idx_q;
  logic [WordW-1:0] e_q, lin_q, thick_q, epa_q, efirst_q;
  logic [7:0]       a_q;
  logic [AW-1:0]    bin_q, k_q;
  logic             neg_q;
  logic [WordW-1:0] mag_q, lbin_q, loss_q, st_q, used_q, slope_q;
  logic [WideW-1:0] m_q, p_q, delta_q;
  logic [SaW-1:0]   sa_q;
  logic [15:0]      steps_q;
  logic [WordW-1:0] eout_q;
  logic [1:0]       stout_q;
  logic [15:0]      cnout_q;

  logic [NW-1:0]    n_w, n_m1;
  logic [WordW-1:0] idx_ext, idx_prev;
  logic [AW-1:0]    idx_addr, prev_addr;

  assign n_w       = (32'(count_q) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_q);
  assign n_m1      = n_w - NW'(1);
  assign idx_ext   = 32'(idx_q);
  assign idx_prev  = idx_ext - 32'd1;
  assign idx_addr  = idx_ext[AW-1:0];
  assign prev_addr = idx_prev[AW-1:0];

  // segment slope terms
  logic             seg_pos, ld_neg;
  logic [WordW-1:0] dl;
  assign seg_pos = e_q > e_rd_q;
  assign ld_neg  = lin_q < l_rd_q;
  assign dl      = ld_neg ? (l_rd_q - lin_q) : (lin_q - l_rd_q);

  // divider and square root
  logic             div_start, div_done, q_over, sqrt_start, sqrt_done, p_zero;
  logic [WideW-1:0] div_num, div_den, div_quo;
  logic [WordW-1:0] root;

  assign p_zero = p_q == '0;
  assign q_over = (div_quo >> (WideW - FRAC_BITS)) != '0;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd_i.op)
      OP_LD_DIFF: begin
        div_start = seg_pos;
        div_num   = WideW'(dl) << FRAC_BITS;
        div_den   = WideW'(e_q - e_rd_q);
      end
      OP_EPA_GO: begin
        div_start = 1'b1;
        div_num   = WideW'(e_q);
        div_den   = WideW'(a_q);
      end
      OP_STEP_DIV: begin
        div_start = !p_zero;
        div_num   = (WideW'(tol_q) << 1) << FRAC_BITS;
        div_den   = p_q;
      end
      default: ;
    endcase
  end

  assign sqrt_start = (cmd_i.op == OP_STEP_WAIT) && div_done && !q_over;

  aeli_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  aeli_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .start_i (sqrt_start),
    .val_i   (div_quo << FRAC_BITS),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // memory access
  always_comb begin
    unique case (cmd_i.op)
      OP_LD_WRITE: rd_addr = prev_addr;
      OP_RD_LAST:  rd_addr = n_m1[AW-1:0];
      OP_SCAN_RD:  rd_addr = k_q;
      OP_BIN_RD:   rd_addr = bin_q;
      default:     rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LD_WRITE) begin
      e_mem[idx_addr] <= e_q;
      l_mem[idx_addr] <= lin_q;
    end
    if (cmd_i.op == OP_LD_STORE) s_mem[prev_addr] <= slope_q;
    e_rd_q <= e_mem[rd_addr];
    l_rd_q <= l_mem[rd_addr];
    s_rd_q <= s_mem[rd_addr];
  end

  // saturated quotient magnitude for a segment slope
  function automatic logic [WideW-1:0] ld_neg_q_sat(input logic [WideW-1:0] q,
                                                    input logic neg);
    logic [WideW-1:0] r;
    if (neg) r = (q > SlopeNegMax) ? SlopeNegMax : q;
    else     r = (q > WideW'(SlopePosMax)) ? WideW'(SlopePosMax) : q;
    return r;
  endfunction

  // interpolation and step terms
  logic             raw_neg;
  logic [WordW-1:0] mag_c, diff_c, loss_c, st_eff, used_c;
  logic [WideW-1:0] interp_p, lo_p, q_sat;
  logic [WordW:0]   sum_c;
  logic [WordW-1:0] e_slow, e_rev;
  logic [WordW:0]   e_sum;

  assign raw_neg  = s_rd_q[WordW-1];
  assign mag_c    = raw_neg ? (WordW'(0) - s_rd_q) : s_rd_q;
  assign diff_c   = epa_q - e_rd_q;
  assign interp_p = WideW'(mag_c) * WideW'(diff_c);
  assign sum_c    = (WordW+1)'(lbin_q) + (WordW+1)'(m_q[WordW-1:0]);

  always_comb begin
    if (neg_q) begin
      loss_c = (m_q > WideW'(lbin_q)) ? '0 : (lbin_q - m_q[WordW-1:0]);
    end else if ((m_q >> WordW) != '0 || sum_c[WordW]) begin
      loss_c = WordMax;
    end else begin
      loss_c = sum_c[WordW-1:0];
    end
  end

  assign lo_p   = (WideW'(sa_q) * WideW'(loss_q[FRAC_BITS-1:0])) >> FRAC_BITS;
  assign st_eff = (st_q < MinStep) ? MinStep : st_q;
  assign used_c = (thick_q < st_eff) ? thick_q : st_eff;
  assign q_sat  = ld_neg_q_sat(div_quo, neg_q);
  assign e_slow = (delta_q > WideW'(e_q)) ? '0 : (e_q - delta_q[WordW-1:0]);
  assign e_sum  = (WordW+1)'(e_q) + (WordW+1)'(delta_q[WordW-1:0]);
  assign e_rev  = ((delta_q >> WordW) != '0 || e_sum[WordW]) ? WordMax : e_sum[WordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      tol_q       <= 32'd655;
      ob_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.op == OP_FINISH;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgEntryCount) count_q <= cfg_wdata_i[6:0];
        if (cfg_idx_i == CfgStepTol)    tol_q   <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_LD_WRITE && idx_ext == '0) ob_q <= 1'b0;
      if (cmd_i.op == OP_LD_DIFF && e_q < e_rd_q)    ob_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LATCH: begin
        mode_q  <= mode_i;
        idx_q   <= entry_index_i;
        e_q     <= energy_in_i;
        lin_q   <= loss_value_i;
        thick_q <= thickness_i;
        a_q     <= (mass_number_i == '0) ? 8'd1 : mass_number_i;
        steps_q <= '0;
      end
      OP_LD_DIFF: begin
        slope_q <= '0;
        neg_q   <= ld_neg;
      end
      OP_LD_WAIT: begin
        if (div_done) slope_q <= neg_q ? (WordW'(0) - q_sat[WordW-1:0]) : q_sat[WordW-1:0];
      end
      OP_EPA_WAIT: begin
        if (div_done) epa_q <= div_quo[WordW-1:0];
      end
      OP_RD_LAST: efirst_q <= e_rd_q;
      OP_RANGE: begin
        bin_q <= '0;
        k_q   <= AW'(1);
      end
      OP_SCAN_CMP: begin
        if (e_rd_q <= epa_q) bin_q <= k_q;
        k_q <= k_q + AW'(1);
      end
      OP_INTERP: begin
        neg_q  <= raw_neg;
        mag_q  <= mag_c;
        lbin_q <= l_rd_q;
        m_q    <= interp_p >> FRAC_BITS;
      end
      OP_LOSS: begin
        loss_q <= loss_c;
        sa_q   <= SaW'(mag_q) * SaW'(a_q);
      end
      OP_PROD_HI: p_q <= WideW'(sa_q) * WideW'(loss_q[WordW-1:FRAC_BITS]);
      OP_PROD_LO: p_q <= p_q + lo_p;
      OP_STEP_DIV: begin
        if (p_zero) st_q <= WordMax;
      end
      OP_STEP_WAIT: begin
        if (div_done && q_over) st_q <= WordMax;
      end
      OP_SQRT_WAIT: begin
        if (sqrt_done) st_q <= root;
      end
      OP_STEP_CLAMP: begin
        st_q   <= st_eff;
        used_q <= used_c;
      end
      OP_DELTA: delta_q <= (WideW'(loss_q) * WideW'(used_q)) >> FRAC_BITS;
      OP_APPLY: begin
        e_q <= (mode_q == ModeSlow) ? e_slow : e_rev;
        if (steps_q != 16'hFFFF) steps_q <= steps_q + 16'd1;
        if (used_q != thick_q) thick_q <= thick_q - st_q;
      end
      OP_FINISH: begin
        eout_q  <= (cmd_i.fin_zero || cmd_i.fin_status != StOk) ? '0 : e_q;
        stout_q <= cmd_i.fin_zero ? StOk : cmd_i.fin_status;
        cnout_q <= cmd_i.fin_zero ? '0 : steps_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.mode         = mode_q;
    stat_o.idx_bad      = idx_ext >= 32'(TABLE_DEPTH);
    stat_o.idx_zero     = idx_ext == '0;
    stat_o.few          = n_w < NW'(2);
    stat_o.order_broken = ob_q;
    stat_o.seg_pos      = seg_pos;
    stat_o.div_done     = div_done;
    stat_o.sqrt_done    = sqrt_done;
    stat_o.out_range    = (epa_q < efirst_q) || (epa_q > e_rd_q);
    stat_o.n_gt2        = n_w > NW'(2);
    stat_o.scan_more    = ((NW+1)'(k_q) + (NW+1)'(2)) < (NW+1)'(n_w);
    stat_o.p_zero       = p_zero;
    stat_o.q_over       = q_over;
    stat_o.last_step    = used_q == thick_q;
  end

  assign done_o       = out_valid_q;
  assign energy_out_o = eout_q;
  assign status_o     = stout_q;
  assign step_count_o = cnout_q;

endmodule

`default_nettype wire

FILE: hdl/aeli_ctrl.sv
// sequencing state machine for table loads and integration steps
`timescale 1ns / 1ps
`default_nettype none

module aeli_ctrl import aeli_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_CHECK      = 5'd1;
  localparam logic [4:0] S_LD_WRITE   = 5'd2;
  localparam logic [4:0] S_LD_DIFF    = 5'd3;
  localparam logic [4:0] S_LD_WAIT    = 5'd4;
  localparam logic [4:0] S_LD_STORE   = 5'd5;
  localparam logic [4:0] S_EPA_GO     = 5'd6;
  localparam logic [4:0] S_EPA_WAIT   = 5'd7;
  localparam logic [4:0] S_RD_FIRST   = 5'd8;
  localparam logic [4:0] S_RD_LAST    = 5'd9;
  localparam logic [4:0] S_RANGE      = 5'd10;
  localparam logic [4:0] S_SCAN_RD    = 5'd11;
  localparam logic [4:0] S_SCAN_CMP   = 5'd12;
  localparam logic [4:0] S_BIN_RD     = 5'd13;
  localparam logic [4:0] S_INTERP     = 5'd14;
  localparam logic [4:0] S_LOSS       = 5'd15;
  localparam logic [4:0] S_PROD_HI    = 5'd16;
  localparam logic [4:0] S_PROD_LO    = 5'd17;
  localparam logic [4:0] S_STEP_DIV   = 5'd18;
  localparam logic [4:0] S_STEP_WAIT  = 5'd19;
  localparam logic [4:0] S_SQRT_WAIT  = 5'd20;
  localparam logic [4:0] S_STEP_CLAMP = 5'd21;
  localparam logic [4:0] S_DELTA      = 5'd22;
  localparam logic [4:0] S_APPLY      = 5'd23;
  localparam logic [4:0] S_FINISH     = 5'd24;

  logic [4:0] state_q, state_d;
  logic       zero_q, zero_d;
  logic [1:0] res_q, res_d;
  dp_op_e     op;

  always_comb begin
    state_d = state_q;
    zero_d  = zero_q;
    res_d   = res_q;
    op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op      = OP_LATCH;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        zero_d = 1'b0;
        res_d  = StOk;
        if (stat_i.mode == ModeNone || (stat_i.mode == ModeLoad && stat_i.idx_bad)) begin
          zero_d  = 1'b1;
          state_d = S_FINISH;
        end else if (stat_i.mode == ModeLoad) begin
          state_d = S_LD_WRITE;
        end else if (stat_i.few) begin
          res_d   = StFew;
          state_d = S_FINISH;
        end else if (stat_i.order_broken) begin
          res_d   = StOrder;
          state_d = S_FINISH;
        end else begin
          state_d = S_EPA_GO;
        end
      end
      S_LD_WRITE: begin
        op      = OP_LD_WRITE;
        zero_d  = 1'b1;
        state_d = stat_i.idx_zero ? S_FINISH : S_LD_DIFF;
      end
      S_LD_DIFF: begin
        op      = OP_LD_DIFF;
        state_d = stat_i.seg_pos ? S_LD_WAIT : S_LD_STORE;
      end
      S_LD_WAIT: begin
        op = OP_LD_WAIT;
        if (stat_i.div_done) state_d = S_LD_STORE;
      end
      S_LD_STORE: begin
        op      = OP_LD_STORE;
        state_d = S_FINISH;
      end
      S_EPA_GO: begin
        op      = OP_EPA_GO;
        state_d = S_EPA_WAIT;
      end
      S_EPA_WAIT: begin
        op = OP_EPA_WAIT;
        if (stat_i.div_done) state_d = S_RD_FIRST;
      end
      S_RD_FIRST: begin
        op      = OP_RD_FIRST;
        state_d = S_RD_LAST;
      end
      S_RD_LAST: begin
        op      = OP_RD_LAST;
        state_d = S_RANGE;
      end
      S_RANGE: begin
        op = OP_RANGE;
        if (stat_i.out_range) begin
          res_d   = StRange;
          state_d = S_FINISH;
        end else begin
          state_d = stat_i.n_gt2 ? S_SCAN_RD : S_BIN_RD;
        end
      end
      S_SCAN_RD: begin
        op      = OP_SCAN_RD;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        op      = OP_SCAN_CMP;
        state_d = stat_i.scan_more ? S_SCAN_RD : S_BIN_RD;
      end
      S_BIN_RD: begin
        op      = OP_BIN_RD;
        state_d = S_INTERP;
      end
      S_INTERP: begin
        op      = OP_INTERP;
        state_d = S_LOSS;
      end
      S_LOSS: begin
        op      = OP_LOSS;
        state_d = S_PROD_HI;
      end
      S_PROD_HI: begin
        op      = OP_PROD_HI;
        state_d = S_PROD_LO;
      end
      S_PROD_LO: begin
        op      = OP_PROD_LO;
        state_d = S_STEP_DIV;
      end
      S_STEP_DIV: begin
        op      = OP_STEP_DIV;
        state_d = stat_i.p_zero ? S_STEP_CLAMP : S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        op = OP_STEP_WAIT;
        if (stat_i.div_done) state_d = stat_i.q_over ? S_STEP_CLAMP : S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        op = OP_SQRT_WAIT;
        if (stat_i.sqrt_done) state_d = S_STEP_CLAMP;
      end
      S_STEP_CLAMP: begin
        op      = OP_STEP_CLAMP;
        state_d = S_DELTA;
      end
      S_DELTA: begin
        op      = OP_DELTA;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        op      = OP_APPLY;
        state_d = stat_i.last_step ? S_FINISH : S_EPA_GO;
      end
      S_FINISH: begin
        op      = OP_FINISH;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      zero_q  <= 1'b0;
      res_q   <= StOk;
    end else begin
      state_q <= state_d;
      zero_q  <= zero_d;
      res_q   <= res_d;
    end
  end

  assign busy             = state_q != S_IDLE;
  assign cmd_o.op         = op;
  assign cmd_o.fin_zero   = zero_q;
  assign cmd_o.fin_status = res_q;

endmodule

`default_nettype wire

FILE: hdl/absorber_energy_loss_integrator.sv
// top level of the absorber energy-loss integrator
//
// usage: pulse start with the item fields while busy is low; the word is
// taken at that edge. mode 0 loads one table point (energy per nucleon,
// stopping power) and the slope of the segment ending there; modes 1 and 2
// walk a particle through the absorber and return its energy after or
// before it. each item gives one result, shown for one cycle with done_o.
// the receiver cannot stall; results are never held back.
// configuration: cfg_we_i writes register cfg_idx_i (0 entry count,
// 1 step tolerance) at once; the user must do so only while busy is low;
// the block does not enforce this. a load at index 0 stores only the point;
// other loads also store a slope, dividing only if the segment rises in
// energy. with n table points a compute item repeats steps, each running
// the shared divider for energy per nucleon and, unless the loss product is
// zero, for step size, the square root unless that quotient overflows,
// and for n > 2 a linear bin scan through the single memory read port.
// the next item is accepted in the cycle the result is shown.
// reset clears the control state, order flag and done strobe and restores
// the configuration defaults; table contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module absorber_energy_loss_integrator import aeli_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       mode_i,
  input  wire logic [5:0]       entry_index_i,
  input  wire logic [WordW-1:0] energy_in_i,
  input  wire logic [WordW-1:0] loss_value_i,
  input  wire logic [WordW-1:0] thickness_i,
  input  wire logic [7:0]       mass_number_i,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [WordW-1:0] cfg_wdata_i,
  output logic                  done_o,
  output logic      [WordW-1:0] energy_out_o,
  output logic      [1:0]       status_o,
  output logic      [15:0]      step_count_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  aeli_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start,
    .busy,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  aeli_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .mode_i, .entry_index_i, .energy_in_i, .loss_value_i,
    .thickness_i, .mass_number_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .done_o, .energy_out_o, .status_o, .step_count_o
  );

endmodule

`default_nettype wire

FILE: hdl/aeli_checker.sv
// port-level checks of the integrator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module aeli_checker import aeli_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done_o,
  input wire logic [WordW-1:0] energy_out_o,
  input wire logic [1:0]       status_o,
  input wire logic [15:0]      step_count_o
);

  // an accepted word always occupies the block
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  // results come out after the work, never while it runs
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("two results in a row");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != StOk |-> energy_out_o == '0)
    else $error("energy nonzero on error");

  a_early_err_nosteps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == StFew || status_o == StOrder) |-> step_count_o == '0)
    else $error("steps counted without integration");

endmodule

bind absorber_energy_loss_integrator aeli_checker u_aeli_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .energy_out_o (energy_out_o),
  .status_o     (status_o),
  .step_count_o (step_count_o)
);

`default_nettype wire
